// ===== hw/rtl/zph_pkg.sv =====
package zph_pkg;

	// key table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int TBL_AW      = $clog2(TABLE_DEPTH);

	// key table layout
	localparam logic [3:0] PIECE_TYPES = 4'd12;
	localparam int CASTLE_BASE = 768;
	localparam int EP_BASE     = 784;
	localparam int SIDE_ADDR   = 848;

	// command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_GEN  = 2'd1;
	localparam logic [1:0] CMD_UPD  = 2'd2;

	// what the fold stage does with one pair of table words
	typedef enum logic [2:0] {
		OP_NONE,
		OP_GEN_ACC,
		OP_GEN_DONE,
		OP_UPD_START,
		OP_UPD_ACC,
		OP_UPD_DONE
	} op_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [9:0]  table_index;
		logic [63:0] key_value;
		logic [5:0]  origin_square;
		logic [5:0]  target_square;
		logic [3:0]  piece_code;
		logic [3:0]  captured_code;
		logic [3:0]  castle_rights;
		logic [5:0]  en_passant_square;
		logic        side_to_move;
		logic        last_square;
	} item_t;

	typedef struct packed {
		logic [63:0] hash_key;
		logic        from_update;
	} result_t;

	// one issued step, travels alongside the table read
	typedef struct packed {
		op_t         op;
		logic        use_a;
		logic        use_b;
		logic [63:0] key_value;
	} tag_t;

	// key table access for one cycle
	typedef struct packed {
		logic              wr_en;
		logic [TBL_AW-1:0] wr_addr;
		logic [63:0]       wr_data;
		logic [TBL_AW-1:0] rd_addr_a;
		logic [TBL_AW-1:0] rd_addr_b;
	} ram_req_t;

endpackage

// ===== hw/rtl/zobrist_position_hasher_top.sv =====
// Zobrist position hasher.
// Input channel item_valid/item_ready/item carries one command word: load a
// key table word, hash one square, or apply an incremental move update.
// Output channel result_valid/result_ready/result carries the position key
// of a last generate square or of an update, flagged by from_update.
// A word is taken into a holding register, then issues one key table access
// per cycle unless stalled: one step for a load, a non-last square or an
// unknown command; a last square reads piece and castle, then en passant and
// side words; an update reads origin and target piece, then capture and
// castle, then en passant and side words. Each issue reads two table words
// through the two read ports of the key table; that port count sets the
// step counts. The next word is taken during the last issue step. A result
// goes through the table read and fold stage into the result register.
// Reset clears the pipeline, the output valid flag and the running key; the
// key table holds undefined data until loaded and needs no clearing pass.
// A stalled receiver holds the result register; loads and non-last squares
// keep flowing, and a second result waits in the fold stage, stalling the
// issue side until the register drains.
module zobrist_position_hasher_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  zph_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output zph_pkg::result_t result
);
	import zph_pkg::*;

	ram_req_t    ram_req;
	tag_t        tag;
	logic        tag_vld;
	logic        stall;
	logic [63:0] rd_a;
	logic [63:0] rd_b;

	zph_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.stall      (stall),
		.ram_req    (ram_req),
		.tag_vld    (tag_vld),
		.tag        (tag)
	);

	zph_key_ram u_key_ram (
		.clk    (clk),
		.rd_en  (!stall),
		.req    (ram_req),
		.rd_a_q (rd_a),
		.rd_b_q (rd_b)
	);

	zph_fold u_fold (
		.clk          (clk),
		.arst_n       (arst_n),
		.tag_vld      (tag_vld),
		.tag          (tag),
		.rd_a         (rd_a),
		.rd_b         (rd_b),
		.stall        (stall),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== hw/rtl/zph_key_ram.sv =====
module zph_key_ram (
	input  logic              clk,
	input  logic              rd_en,
	input  zph_pkg::ram_req_t req,
	output logic [63:0]       rd_a_q,
	output logic [63:0]       rd_b_q
);
	import zph_pkg::*;

	logic [63:0] key_mem [TABLE_DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			key_mem[req.wr_addr] <= req.wr_data;
		end
		if (rd_en) begin
			rd_a_q <= key_mem[req.rd_addr_a];
			rd_b_q <= key_mem[req.rd_addr_b];
		end
	end

endmodule

// ===== hw/rtl/zph_seq.sv =====
module zph_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  zph_pkg::item_t    item,
	input  logic              stall,
	output zph_pkg::ram_req_t ram_req,
	output logic              tag_vld,
	output zph_pkg::tag_t     tag
);
	import zph_pkg::*;

	item_t             item_q;
	logic              busy_q;
	logic [1:0]        step_q;
	logic [1:0]        final_step;
	logic              last_step;
	logic              piece_ok;
	logic              capt_ok;
	logic              idx_ok;
	logic [TBL_AW-1:0] pk_org;
	logic [TBL_AW-1:0] pk_tgt;
	logic [TBL_AW-1:0] cap_tgt;
	logic [TBL_AW-1:0] castle_addr;
	logic [TBL_AW-1:0] ep_addr;
	logic [TBL_AW-1:0] side_addr;

	// count table read steps of the held word
	always_comb begin
		case (item_q.command)
			CMD_GEN: final_step = item_q.last_square ? 2'd1 : 2'd0;
			CMD_UPD: final_step = 2'd2;
			default: final_step = 2'd0;
		endcase
	end

	assign last_step  = (step_q == final_step);
	assign item_ready = !stall && (!busy_q || last_step);
	assign tag_vld    = busy_q;

	// table addresses
	assign piece_ok    = (item_q.piece_code < PIECE_TYPES);
	assign capt_ok     = (item_q.captured_code < PIECE_TYPES);
	assign idx_ok      = ({1'b0, item_q.table_index} < 11'(TABLE_DEPTH));
	assign pk_org      = TBL_AW'({item_q.piece_code, item_q.origin_square});
	assign pk_tgt      = TBL_AW'({item_q.piece_code, item_q.target_square});
	assign cap_tgt     = TBL_AW'({item_q.captured_code, item_q.target_square});
	assign castle_addr = TBL_AW'(CASTLE_BASE) + TBL_AW'(item_q.castle_rights);
	assign ep_addr     = TBL_AW'(EP_BASE) + TBL_AW'(item_q.en_passant_square);
	assign side_addr   = TBL_AW'(SIDE_ADDR);

	// issue one read pair or one write per cycle when not stalled
	always_comb begin
		tag.op            = OP_NONE;
		tag.use_a         = 1'b0;
		tag.use_b         = 1'b0;
		tag.key_value     = item_q.key_value;
		ram_req.wr_en     = 1'b0;
		ram_req.wr_addr   = item_q.table_index[TBL_AW-1:0];
		ram_req.wr_data   = item_q.key_value;
		ram_req.rd_addr_a = pk_org;
		ram_req.rd_addr_b = castle_addr;
		case (item_q.command)
			CMD_LOAD: begin
				ram_req.wr_en = busy_q && !stall && idx_ok;
			end
			CMD_GEN: begin
				if (step_q == 2'd0) begin
					tag.op    = OP_GEN_ACC;
					tag.use_a = piece_ok;
					tag.use_b = item_q.last_square;
				end else begin
					tag.op            = OP_GEN_DONE;
					tag.use_a         = 1'b1;
					tag.use_b         = !item_q.side_to_move;
					ram_req.rd_addr_a = ep_addr;
					ram_req.rd_addr_b = side_addr;
				end
			end
			CMD_UPD: begin
				if (step_q == 2'd0) begin
					tag.op            = OP_UPD_START;
					tag.use_a         = piece_ok;
					tag.use_b         = piece_ok;
					ram_req.rd_addr_b = pk_tgt;
				end else if (step_q == 2'd1) begin
					tag.op            = OP_UPD_ACC;
					tag.use_a         = capt_ok;
					tag.use_b         = 1'b1;
					ram_req.rd_addr_a = cap_tgt;
				end else begin
					tag.op            = OP_UPD_DONE;
					tag.use_a         = 1'b1;
					tag.use_b         = !item_q.side_to_move;
					ram_req.rd_addr_a = ep_addr;
					ram_req.rd_addr_b = side_addr;
				end
			end
			default: begin
				tag.op = OP_NONE;
			end
		endcase
	end

	// advance the step counter, hold on stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
		end else if (!stall) begin
			if (item_valid && item_ready) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q && last_step) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	// capture the accepted word
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
	end

`ifndef ASSERT_OFF
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q <= final_step))
		else $error("step counter past last step");
	a_write_load_only: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.wr_en |-> (busy_q && !stall && item_q.command == CMD_LOAD))
		else $error("table write outside a load word");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> ($stable(step_q) && $stable(busy_q)))
		else $error("sequencer moved during stall");
`endif

endmodule

// ===== hw/rtl/zph_fold.sv =====
module zph_fold (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tag_vld,
	input  zph_pkg::tag_t    tag,
	input  logic [63:0]      rd_a,
	input  logic [63:0]      rd_b,
	output logic             stall,
	output logic             result_valid,
	input  logic             result_ready,
	output zph_pkg::result_t result
);
	import zph_pkg::*;

	logic        vld_s1;
	tag_t        tag_s1;
	logic [63:0] run_key_q;
	logic [63:0] upd_key_q;
	logic        result_valid_q;
	result_t     result_q;
	logic        emit;
	logic        fire;
	logic [63:0] sum;

	// fold both masked table words
	assign sum   = (tag_s1.use_a ? rd_a : 64'd0) ^ (tag_s1.use_b ? rd_b : 64'd0);
	assign emit  = (tag_s1.op == OP_GEN_DONE) || (tag_s1.op == OP_UPD_DONE);
	assign stall = vld_s1 && emit && result_valid_q && !result_ready;
	assign fire  = vld_s1 && !stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// control and running key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			run_key_q      <= 64'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (!stall) begin
				vld_s1 <= tag_vld;
			end
			if (fire) begin
				case (tag_s1.op)
					OP_GEN_ACC:  run_key_q <= run_key_q ^ sum;
					OP_GEN_DONE: run_key_q <= 64'd0;
					default:     run_key_q <= run_key_q;
				endcase
			end
			if (fire && emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// step tag, update key and result word
	always_ff @(posedge clk) begin
		if (!stall) begin
			tag_s1 <= tag;
		end
		if (fire) begin
			case (tag_s1.op)
				OP_UPD_START: upd_key_q <= tag_s1.key_value ^ sum;
				OP_UPD_ACC:   upd_key_q <= upd_key_q ^ sum;
				OP_GEN_DONE: begin
					result_q.hash_key    <= run_key_q ^ sum;
					result_q.from_update <= 1'b0;
				end
				OP_UPD_DONE: begin
					result_q.hash_key    <= upd_key_q ^ sum;
					result_q.from_update <= 1'b1;
				end
				default: begin
					upd_key_q <= upd_key_q;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && tag_s1.op == OP_GEN_DONE) |=> (run_key_q == 64'd0))
		else $error("running key not cleared after generate");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit) |-> (!result_valid_q || result_ready))
		else $error("result word overwritten");
	a_update_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && tag_s1.op == OP_UPD_DONE) |=> (result_valid_q && result_q.from_update))
		else $error("update result without update flag");
`endif

endmodule
